>>> hw/rtl/kli_pkg.sv
// keyframe interpolator package: table geometry, field widths, shared types
// no dependencies
package kli_pkg;
  localparam int unsigned MaxKeys = 64;
  localparam int unsigned IdxW = $clog2(MaxKeys);
  localparam int unsigned CntW = 7;
  localparam int unsigned TimeW = 24;
  localparam int unsigned ValW = 32;
  localparam int unsigned FracW = 16;
  localparam int unsigned DivCntW = $clog2(FracW);

  typedef logic [TimeW-1:0] time_t;
  typedef logic signed [ValW-1:0] val_t;

  typedef enum logic {
    OpWrite = 1'b0,
    OpSample = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    StIdle,
    StRead0,
    StScan,
    StLoad,
    StDiv,
    StMul,
    StOut
  } state_e;

  typedef struct packed {
    time_t t0;
    time_t t1;
    val_t x0;
    val_t y0;
    val_t z0;
    val_t x1;
    val_t y1;
    val_t z1;
  } seg_t;
endpackage

>>> hw/rtl/kli_ram.sv
// generic single-port-write, one-read RAM with registered read data
// no dependencies
module kli_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> hw/rtl/kli_div_cell.sv
// one restoring-division cell: one quotient bit per cycle while enabled, neighbor chained
// depends on kli_pkg
module kli_div_cell (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [kli_pkg::TimeW:0] rem_i,
  input  logic [kli_pkg::TimeW-1:0] den_i,
  output logic [kli_pkg::TimeW:0] rem_o,
  output logic                   bit_o
);
  import kli_pkg::*;
  logic [TimeW:0] rem_q;
  logic [TimeW+1:0] sh;
  logic ge;

  always_comb begin
    sh = {rem_i, 1'b0};
    ge = sh >= {2'b00, den_i};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= ge ? (TimeW+1)'(sh - {2'b00, den_i}) : sh[TimeW:0];
      bit_o <= ge;
    end
  end
  assign rem_o = rem_q;
endmodule

>>> hw/rtl/kli_lerp_cell.sv
// one lerp lane: start + floor(factor * (end - start) / 2^16)
// depends on kli_pkg
module kli_lerp_cell (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  kli_pkg::val_t            a_i,
  input  kli_pkg::val_t            b_i,
  input  logic [kli_pkg::FracW-1:0] f_i,
  output kli_pkg::val_t            y_o
);
  import kli_pkg::*;
  logic signed [ValW:0] d;
  logic signed [ValW+FracW+1:0] p;

  assign d = {b_i[ValW-1], b_i} - {a_i[ValW-1], a_i};
  assign p = d * $signed({1'b0, f_i});

  // arithmetic shift gives floor rounding
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y_o <= ValW'(a_i + ValW'(p >>> FracW));
    end
  end
endmodule

>>> hw/rtl/keyframe_linear_interpolator.sv
// keyframe linear interpolator: four key rams, serial segment scan, a chain of
// 16 division cells and three lerp lanes; depends on kli_pkg and all kli cells
// a write gives no result; a sample steps through read, scan, load, divide, multiply
// and output; past the last key it skips load and divide, with one key also the scan
// throughput: one sample in work, next request taken the cycle after the result
// register loads; reset: key_count 1, idle, table undefined until written
module keyframe_linear_interpolator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [5:0]  key_index_i,
  input  logic [23:0] key_time_i,
  input  logic signed [31:0] value_x_i,
  input  logic signed [31:0] value_y_i,
  input  logic signed [31:0] value_z_i,
  input  logic [23:0] sample_time_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [31:0] out_z_o,
  output logic        status_o
);
  import kli_pkg::*;

  state_e state_q, state_d;
  logic [CntW-1:0] key_count_q;
  logic [CntW-1:0] n_eff;
  logic [IdxW-1:0] idx_q;         // key shown by the rams during the scan
  logic [DivCntW-1:0] dcnt_q;     // active division cell
  time_t t_q;                     // sample time of the request in work
  seg_t seg_q;
  logic zero_fac_q;               // factor pinned to zero
  logic flag_q;                   // sample time at or past the last key
  logic out_valid_q, status_q;
  val_t ox_q, oy_q, oz_q;
  val_t x_lerp, y_lerp, z_lerp;

  // ram address and read data
  logic wr_en, smp_en;
  logic [IdxW-1:0] raddr;
  time_t rt;
  val_t rx, ry, rz;

  logic scan_hit, scan_last, out_free, out_load;

  assign wr_en = in_valid_i && in_ready_o && (op_e'(op_i) == OpWrite);
  assign smp_en = in_valid_i && in_ready_o && (op_e'(op_i) == OpSample);

  kli_ram #(.Width(TimeW), .Depth(MaxKeys)) u_tram (.clk_i, .we_i(wr_en),
    .waddr_i(key_index_i), .wdata_i(key_time_i), .raddr_i(raddr), .rdata_o(rt));
  kli_ram #(.Width(ValW), .Depth(MaxKeys)) u_xram (.clk_i, .we_i(wr_en),
    .waddr_i(key_index_i), .wdata_i(value_x_i), .raddr_i(raddr), .rdata_o(rx));
  kli_ram #(.Width(ValW), .Depth(MaxKeys)) u_yram (.clk_i, .we_i(wr_en),
    .waddr_i(key_index_i), .wdata_i(value_y_i), .raddr_i(raddr), .rdata_o(ry));
  kli_ram #(.Width(ValW), .Depth(MaxKeys)) u_zram (.clk_i, .we_i(wr_en),
    .waddr_i(key_index_i), .wdata_i(value_z_i), .raddr_i(raddr), .rdata_o(rz));

  // effective count: zero acts as one, beyond table saturates
  always_comb begin
    if (key_count_q == '0) n_eff = CntW'(1);
    else if (key_count_q > CntW'(MaxKeys)) n_eff = CntW'(MaxKeys);
    else n_eff = key_count_q;
  end

  // scan: rams show key idx_q, hit on the first key time above the sample time
  assign scan_hit = t_q < rt;
  assign scan_last = ({1'b0, idx_q} + 1'b1) >= n_eff;
  // result register frees when empty or drained in this cycle
  assign out_free = !out_valid_q || out_ready_i;

  // divider chain: 16 cells, one active per cycle by dcnt, msb first
  // numerator below denominator whenever the factor is used
  logic [TimeW:0] rem [FracW+1];
  logic [FracW-1:0] qbits, fac;
  time_t num, den;
  assign num = t_q - seg_q.t0;
  assign den = seg_q.t1 - seg_q.t0;
  assign rem[0] = {1'b0, num};

  genvar gi;
  for (gi = 0; gi < FracW; gi++) begin : g_div
    kli_div_cell u_cell (.clk_i, .en_i(state_q == StDiv && dcnt_q == DivCntW'(gi)),
      .rem_i(rem[gi]), .den_i(den), .rem_o(rem[gi+1]), .bit_o(qbits[FracW-1-gi]));
  end

  // flat, backward, before-start, past-last and single-key cases use factor zero
  assign fac = zero_fac_q ? '0 : qbits;

  kli_lerp_cell u_lx (.clk_i, .en_i(state_q == StMul), .a_i(seg_q.x0),
    .b_i(seg_q.x1), .f_i(fac), .y_o(x_lerp));
  kli_lerp_cell u_ly (.clk_i, .en_i(state_q == StMul), .a_i(seg_q.y0),
    .b_i(seg_q.y1), .f_i(fac), .y_o(y_lerp));
  kli_lerp_cell u_lz (.clk_i, .en_i(state_q == StMul), .a_i(seg_q.z0),
    .b_i(seg_q.z1), .f_i(fac), .y_o(z_lerp));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (smp_en) state_d = StRead0;
      end
      StRead0: begin
        // key 0 on the ram outputs; one key needs no scan
        if (n_eff == CntW'(1)) state_d = StMul;
        else state_d = StScan;
      end
      StScan: begin
        if (scan_hit) state_d = StLoad;
        else if (scan_last) state_d = StMul;
      end
      StLoad: state_d = StDiv;
      StDiv: begin
        if (dcnt_q == DivCntW'(FracW - 1)) state_d = StMul;
      end
      StMul: state_d = StOut;
      StOut: begin
        // wait here while the previous result is still held
        if (out_free) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // state outputs: ready, ram address, result load
  always_comb begin
    in_ready_o = 1'b0;
    raddr = '0;
    out_load = 1'b0;
    case (state_q)
      StIdle: in_ready_o = 1'b1;
      StRead0: raddr = IdxW'(1);
      // on a hit fetch the start key, else the next candidate
      StScan: raddr = scan_hit ? idx_q - 1'b1 : idx_q + 1'b1;
      StOut: out_load = out_free;
      default: raddr = '0;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      key_count_q <= CntW'(1);
      idx_q <= '0;
      dcnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) key_count_q <= cfg_wdata_i;
      if (state_q == StRead0) idx_q <= IdxW'(1);
      else if (state_q == StScan && !scan_hit && !scan_last) idx_q <= idx_q + 1'b1;
      if (state_q == StLoad) dcnt_q <= '0;
      else if (state_q == StDiv) dcnt_q <= dcnt_q + 1'b1;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        if (smp_en) t_q <= sample_time_i;
      end
      StRead0: begin
        // key 0 at both ends: a miss or a single key returns it unchanged
        seg_q.x0 <= rx; seg_q.y0 <= ry; seg_q.z0 <= rz;
        seg_q.x1 <= rx; seg_q.y1 <= ry; seg_q.z1 <= rz;
        flag_q <= 1'b0;
        zero_fac_q <= (n_eff == CntW'(1));
      end
      StScan: begin
        if (scan_hit) begin
          seg_q.t1 <= rt; seg_q.x1 <= rx; seg_q.y1 <= ry; seg_q.z1 <= rz;
        end else if (scan_last) begin
          flag_q <= 1'b1;
          zero_fac_q <= 1'b1;
        end
      end
      StLoad: begin
        // start key arrives, end key already held
        seg_q.t0 <= rt; seg_q.x0 <= rx; seg_q.y0 <= ry; seg_q.z0 <= rz;
        zero_fac_q <= (seg_q.t1 <= rt) || (t_q <= rt);
      end
      StOut: begin
        if (out_free) begin
          ox_q <= x_lerp; oy_q <= y_lerp; oz_q <= z_lerp;
          status_q <= flag_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o = ox_q;
  assign out_y_o = oy_q;
  assign out_z_o = oz_q;
  assign status_o = status_q;

`ifndef SYNTHESIS
  // a waiting result holds its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_x_o) &&
    $stable(out_y_o) && $stable(out_z_o) && $stable(status_o))
    else $error("result changed while waiting");
  // results appear only out of the output state
  a_out_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == StOut) else $error("spurious result");
  // restoring division leaves a remainder below the divisor
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StMul && !zero_fac_q |-> rem[FracW] < {1'b0, den})
    else $error("divider remainder out of range");
`endif
endmodule

>>> sim/keyframe_linear_interpolator_tb.sv
// testbench for keyframe_linear_interpolator: drives keyframe writes and samples,
// predicts each interpolated vector in the bench and checks every response
// depends on kli_pkg and keyframe_linear_interpolator
`timescale 1ns / 1ps

module keyframe_linear_interpolator_tb;
  import kli_pkg::*;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        flag;
  } lerp_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [6:0]  cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        op_i = 1'b0;
  logic [5:0]  key_index_i = '0;
  logic [23:0] key_time_i = '0;
  logic signed [31:0] value_x_i = '0;
  logic signed [31:0] value_y_i = '0;
  logic signed [31:0] value_z_i = '0;
  logic [23:0] sample_time_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic signed [31:0] out_x_o;
  logic signed [31:0] out_y_o;
  logic signed [31:0] out_z_o;
  logic        status_o;

  keyframe_linear_interpolator uut (.*);

  // shadow copy of the key table and the count register
  logic [23:0] shadow_time [MaxKeys];
  logic [31:0] shadow_x [MaxKeys];
  logic [31:0] shadow_y [MaxKeys];
  logic [31:0] shadow_z [MaxKeys];
  logic [6:0]  shadow_count;

  lerp_res_t   pending_lerp_q [$];
  int          mismatches = 0;
  int          requests_sent = 0;
  int          samples_checked = 0;
  bit          no_idle = 1'b0;
  int          rx_hold = 0;
  int          rx_stall = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("timeout at %0t", $time);
    $display("end of test: mismatches");
    $finish;
  end

  // one lerp lane: floor of factor * (end - start) / 2^16, added to start
  function automatic logic [31:0] lerp_lane(logic [31:0] a, logic [31:0] b,
                                            longint factor);
    longint s, d, p;
    s = longint'(signed'(a));
    d = longint'(signed'(b)) - s;
    p = d * factor;
    return 32'(s + (p >>> 16));
  endfunction

  function automatic lerp_res_t predict_sample(logic [23:0] t);
    lerp_res_t r;
    int n, seg;
    bit found;
    longint t0, t1, factor;
    n = shadow_count;
    if (n == 0) n = 1;
    if (n > MaxKeys) n = MaxKeys;
    r = '{shadow_x[0], shadow_y[0], shadow_z[0], 1'b0};
    if (n == 1) return r;
    found = 1'b0;
    seg = 0;
    for (int i = 0; i + 1 < n; i++) begin
      if (t < shadow_time[i+1]) begin
        seg = i;
        found = 1'b1;
        break;
      end
    end
    if (!found) begin
      r.flag = 1'b1;
      return r;
    end
    t0 = shadow_time[seg];
    t1 = shadow_time[seg+1];
    // flat or backward segments and times before the start key pin to start
    if (t1 <= t0 || longint'(t) <= t0) factor = 0;
    else factor = ((longint'(t) - t0) << 16) / (t1 - t0);
    r.x = lerp_lane(shadow_x[seg], shadow_x[seg+1], factor);
    r.y = lerp_lane(shadow_y[seg], shadow_y[seg+1], factor);
    r.z = lerp_lane(shadow_z[seg], shadow_z[seg+1], factor);
    return r;
  endfunction

  // sender: gap, hold valid until accepted, then update the shadow table
  task automatic send_req(op_e op, logic [5:0] idx, logic [23:0] kt,
                          logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                          logic [23:0] st);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    repeat (gap) @(negedge clk_i);
    in_valid_i = 1'b1;
    op_i = op;
    key_index_i = idx;
    key_time_i = kt;
    value_x_i = vx;
    value_y_i = vy;
    value_z_i = vz;
    sample_time_i = st;
    do @(posedge clk_i); while (!in_ready_o);
    if (op == OpWrite) begin
      shadow_time[idx] = kt;
      shadow_x[idx] = vx;
      shadow_y[idx] = vy;
      shadow_z[idx] = vz;
    end else begin
      pending_lerp_q.push_back(predict_sample(st));
    end
    requests_sent++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic write_key(int idx, logic [23:0] kt, logic [31:0] vx,
                           logic [31:0] vy, logic [31:0] vz);
    send_req(OpWrite, 6'(idx), kt, vx, vy, vz, 24'($urandom));
  endtask

  task automatic sample_at(logic [23:0] st);
    send_req(OpSample, 6'($urandom), 24'($urandom), $urandom, $urandom,
             $urandom, st);
  endtask

  // wait until every response is back, then cover the scan latency
  task automatic drain();
    int waited;
    waited = 0;
    while (pending_lerp_q.size() != 0 && waited < 500000) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_lerp_q.size() != 0) begin
      $display("%0t: %0d responses never arrived", $time, pending_lerp_q.size());
      mismatches++;
    end
    repeat (100) @(posedge clk_i);
  endtask

  // key_count only changes while the block sits idle
  task automatic set_key_count(logic [6:0] cnt);
    drain();
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = cnt;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    shadow_count = cnt;
  endtask

  // receiver ready: long hold, then per-response random stall
  initial begin
    forever begin
      @(negedge clk_i);
      if (rx_hold > 0) begin
        out_ready_i = 1'b0;
        rx_hold--;
      end else if (rx_stall > 0 && !no_idle) begin
        out_ready_i = 1'b0;
        rx_stall--;
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  // response check against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      lerp_res_t want;
      if (pending_lerp_q.size() == 0) begin
        $display("%0t: unexpected response x=%h y=%h z=%h status=%b", $time,
                 out_x_o, out_y_o, out_z_o, status_o);
        mismatches++;
      end else begin
        want = pending_lerp_q.pop_front();
        if (out_x_o !== want.x) begin
          $display("%0t: out_x expected %h actual %h", $time, want.x, out_x_o);
          mismatches++;
        end
        if (out_y_o !== want.y) begin
          $display("%0t: out_y expected %h actual %h", $time, want.y, out_y_o);
          mismatches++;
        end
        if (out_z_o !== want.z) begin
          $display("%0t: out_z expected %h actual %h", $time, want.z, out_z_o);
          mismatches++;
        end
        if (status_o !== want.flag) begin
          $display("%0t: status expected %b actual %b", $time, want.flag, status_o);
          mismatches++;
        end
      end
      samples_checked++;
      rx_stall = $urandom_range(0, 8);
    end
  end

  // fill every slot so no sample ever reads an unwritten entry
  task automatic test_fill_table();
    for (int k = 0; k < MaxKeys; k++) begin
      write_key(k, 24'(1000 + k * 4000), $urandom, $urandom, $urandom);
    end
  endtask

  task automatic test_directed();
    // full-scale swing on segment 0, value extremes on each lane
    write_key(0, 24'd1000, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000);
    write_key(1, 24'd5000, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
    // flat segment and backward segment
    write_key(3, 24'd9000, 32'h1234_5678, 32'h8765_4321, 32'h0000_ffff);
    write_key(4, 24'd9000, 32'h7654_3210, 32'h0123_4567, 32'hffff_0000);
    write_key(5, 24'd8000, 32'h1111_1111, 32'h2222_2222, 32'h3333_3333);
    write_key(6, 24'hff_ffff, 32'h0, 32'h0, 32'h0);
    // single key answers key 0
    set_key_count(7'd1);
    sample_at(24'd3000);
    // zero acts as one
    set_key_count(7'd0);
    sample_at(24'hff_ffff);
    set_key_count(7'd2);
    sample_at(24'd0);          // before first key
    sample_at(24'd1000);       // exactly on key 0
    sample_at(24'd3000);
    sample_at(24'd4999);
    sample_at(24'd5000);       // at last key: flagged
    sample_at(24'hff_ffff);
    set_key_count(7'd7);
    sample_at(24'd8999);       // lands in the segment from key 1 to key 2
    sample_at(24'd9000);       // lands in the segment from key 5 to key 6
    sample_at(24'hff_fffe);
    sample_at(24'hff_ffff);    // nothing above it: flagged
    // above the table size saturates
    set_key_count(7'd127);
    sample_at(24'hff_ffff);
    sample_at(24'd123456);
    set_key_count(7'd64);
    sample_at(24'h7f_ffff);
  endtask

  // load a random table of n keys, mostly ascending times
  task automatic load_table(int n);
    logic [23:0] t;
    bit ordered;
    ordered = ($urandom_range(0, 9) != 0);
    t = 24'($urandom_range(0, 4000));
    for (int k = 0; k < n; k++) begin
      if (!ordered) t = 24'($urandom);
      write_key(k, t, $urandom, $urandom, $urandom);
      if ($urandom_range(0, 15) != 0)
        t = 24'(int'(t) + $urandom_range(1, 16777215 / MaxKeys));
    end
  endtask

  task automatic sample_burst(int n, int cnt);
    int k;
    logic [23:0] st;
    for (int s = 0; s < cnt; s++) begin
      k = $urandom_range(0, n - 1);
      case ($urandom_range(0, 5))
        0: st = 24'($urandom);
        1: st = shadow_time[k];
        2: st = 24'(shadow_time[k] + $urandom_range(0, 3) - 1);
        3: st = 24'hff_ffff;
        default: st = 24'(shadow_time[k] + $urandom_range(0, 300000));
      endcase
      sample_at(st);
    end
  endtask

  task automatic test_random();
    int n;
    while (requests_sent < 1850) begin
      case ($urandom_range(0, 9))
        0: n = 64;
        1: n = 1;
        2: n = 2;
        default: n = $urandom_range(2, 16);
      endcase
      no_idle = ($urandom_range(0, 4) == 0);
      set_key_count(7'(n));
      load_table(n);
      sample_burst(n, $urandom_range(20, 50));
    end
    no_idle = 1'b0;
  endtask

  // response side stops for a long while, input side keeps pushing
  task automatic test_backpressure();
    set_key_count(7'd8);
    load_table(8);
    rx_hold = 400;
    no_idle = 1'b1;
    sample_burst(8, 12);
    no_idle = 1'b0;
    // input side pauses until everything is back
    drain();
    sample_burst(8, 12);
  endtask

  initial begin
    shadow_count = 7'd1;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_fill_table();
    test_directed();
    test_backpressure();
    test_random();
    drain();
    $display("sent %0d requests, checked %0d interpolated responses", requests_sent,
             samples_checked);
    $display("covered key counts 0 to 127, flat and backward segments, overrun");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

>>> filelist.f
hw/rtl/kli_pkg.sv
hw/rtl/kli_ram.sv
hw/rtl/kli_div_cell.sv
hw/rtl/kli_lerp_cell.sv
hw/rtl/keyframe_linear_interpolator.sv
sim/keyframe_linear_interpolator_tb.sv
